@@ rtl/cllc_pkg.sv @@
// ----------------------------------------------------------------------------
// cllc_pkg
// Types, keyword table and byte classes for the logical line counter.
// ----------------------------------------------------------------------------
package cllc_pkg;

  localparam int KW_COUNT   = 11;
  localparam int KW_MAX_LEN = 7;

  typedef enum logic [2:0] {
    LEX_CODE    = 3'd0,
    LEX_COMMENT = 3'd1,
    LEX_STRING  = 3'd2,
    LEX_CHAR    = 3'd3,
    LEX_PREPROC = 3'd4
  } lex_mode_t;

  typedef logic [7:0] tok_chars_t [KW_MAX_LEN];

  typedef struct packed {
    logic [31:0] line_count;
    logic [1:0]  added;
    logic [2:0]  lex_mode;
  } result_t;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"d", "e", "f", "a", "u", "l", "t"},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"e", "n", "u", "m", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "u", "c", "t", 8'h00},
    '{"s", "w", "i", "t", "c", "h", 8'h00},
    '{"u", "n", "i", "o", "n", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd7, 3'd2, 3'd4, 3'd4, 3'd3, 3'd2, 3'd6, 3'd6, 3'd5, 3'd5
  };

  function automatic logic kw_hit(input tok_chars_t chars, input logic [2:0] len);
    logic hit;
    logic eq;
    hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      eq = (KW_LEN[k] == len);
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if ((i < int'(len)) && (chars[i] != KW_TEXT[k][i])) begin
          eq = 1'b0;
        end
      end
      hit = hit | eq;
    end
    return hit;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
  endfunction

endpackage

@@ rtl/c_logical_loc_counter.sv @@
// ----------------------------------------------------------------------------
// c_logical_loc_counter
// Scans C source one item (byte) at a time and counts logical lines.
// ----------------------------------------------------------------------------
// Output: the result of an item is registered into the output register, or
// into the skid entry first while the output side stalls.
// Throughput: one item per cycle while in_stall is low; a two-entry output
// buffer lets one more item be accepted while the output side stalls.
// Reset: rst_n is synchronous and clears the lexer state, count and buffer.
module c_logical_loc_counter #(
  parameter int TOKEN_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_line_count,
  output logic [1:0]  out_added,
  output logic [2:0]  out_lex_mode
);

  localparam int TLW = $clog2(TOKEN_CHARS + 2);
  localparam logic [TLW-1:0] TL_MAX      = TLW'(TOKEN_CHARS);
  localparam logic [TLW-1:0] TL_TOO_LONG = TLW'(TOKEN_CHARS + 1);
  localparam logic [TLW-1:0] TL_KW_MAX   = TLW'(cllc_pkg::KW_MAX_LEN);

  cllc_pkg::lex_mode_t  mode_r, mode_nxt, cur_mode;
  logic                 esc_r, esc_nxt, cur_esc;
  logic [7:0]           prev_r, cur_prev;
  logic [TLW-1:0]       tl_r, tl_nxt, cur_tl;
  logic [31:0]          count_r, count_nxt, cur_count;
  cllc_pkg::tok_chars_t tok_r, tok_nxt;

  logic           acc, out_pop;
  logic [7:0]     c;
  logic           do_flush, flush_hit, bump;
  logic [TLW-1:0] flush_len;
  logic [1:0]     hits;
  logic [32:0]    sum;
  cllc_pkg::result_t res, out_r, skid_r;
  logic           out_vld_r, skid_vld_r;

  assign acc      = in_valid && !in_stall;
  assign out_pop  = out_valid && !out_stall;
  assign in_stall = skid_vld_r;
  assign c        = in_byte_in;

  assign cur_mode  = in_restart ? cllc_pkg::LEX_CODE : mode_r;
  assign cur_esc   = in_restart ? 1'b0 : esc_r;
  assign cur_prev  = in_restart ? 8'h00 : prev_r;
  assign cur_tl    = in_restart ? '0 : tl_r;
  assign cur_count = in_restart ? '0 : count_r;

  always_comb begin
    mode_nxt = cur_mode;
    case (cur_mode)
      cllc_pkg::LEX_COMMENT: begin
        if (cur_prev == "*" && c == "/") mode_nxt = cllc_pkg::LEX_CODE;
      end
      cllc_pkg::LEX_STRING: begin
        if (!cur_esc && c == "\"") mode_nxt = cllc_pkg::LEX_CODE;
      end
      cllc_pkg::LEX_CHAR: begin
        if (!cur_esc && c == "'") mode_nxt = cllc_pkg::LEX_CODE;
      end
      cllc_pkg::LEX_PREPROC: begin
        if (cur_prev != "\\" && c == "\n") mode_nxt = cllc_pkg::LEX_CODE;
      end
      default: begin
        mode_nxt = cllc_pkg::LEX_CODE;
        if (c == "*" && cur_prev == "/") mode_nxt = cllc_pkg::LEX_COMMENT;
        else if (c == "\"") mode_nxt = cllc_pkg::LEX_STRING;
        else if (c == "'") mode_nxt = cllc_pkg::LEX_CHAR;
        else if (c == "#") mode_nxt = cllc_pkg::LEX_PREPROC;
      end
    endcase
  end

  always_comb begin
    esc_nxt   = cur_esc;
    tl_nxt    = cur_tl;
    tok_nxt   = tok_r;
    do_flush  = 1'b0;
    flush_len = cur_tl;
    bump      = 1'b0;
    case (cur_mode)
      cllc_pkg::LEX_COMMENT, cllc_pkg::LEX_PREPROC: begin
      end
      cllc_pkg::LEX_STRING, cllc_pkg::LEX_CHAR: begin
        if (cur_esc) esc_nxt = 1'b0;
        else if (c == "\\") esc_nxt = 1'b1;
      end
      default: begin
        if (c == "*" && cur_prev == "/") begin
          if (cur_tl == TLW'(1) || cur_tl > TL_MAX) begin
            tl_nxt = '0;
          end else if (cur_tl >= TLW'(2)) begin
            do_flush  = 1'b1;
            flush_len = cur_tl - TLW'(1);
          end
        end else if (c == "\"" || c == "'" || cllc_pkg::is_space(c)) begin
          do_flush = 1'b1;
        end else if (c == "#") begin
          bump = 1'b1;
        end else if (cllc_pkg::is_punct(c) && c != "_") begin
          do_flush = 1'b1;
          bump     = (c == ";" || c == "," || c == "}");
        end else if (c != 8'h00) begin
          if (cur_tl < TL_MAX) begin
            if (cur_tl < TL_KW_MAX) tok_nxt[cur_tl[2:0]] = c;
            tl_nxt = cur_tl + TLW'(1);
          end else begin
            tl_nxt = TL_TOO_LONG;
          end
        end
      end
    endcase
    flush_hit = do_flush && (cur_tl != '0) && (cur_tl <= TL_MAX) &&
                (flush_len <= TL_KW_MAX) && cllc_pkg::kw_hit(tok_r, flush_len[2:0]);
    if (do_flush) tl_nxt = '0;
    hits      = {1'b0, flush_hit} + {1'b0, bump};
    sum       = {1'b0, cur_count} + 33'(hits);
    count_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    res.line_count = count_nxt;
    res.added      = hits;
    res.lex_mode   = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= cllc_pkg::LEX_CODE;
      esc_r   <= 1'b0;
      prev_r  <= 8'h00;
      tl_r    <= '0;
      count_r <= '0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      esc_r   <= esc_nxt;
      prev_r  <= c;
      tl_r    <= tl_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_pop) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= acc;
      end
    end else if (acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_pop) begin
      if (skid_vld_r) out_r <= skid_r;
      else if (acc) out_r <= res;
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_line_count = out_r.line_count;
  assign out_added      = out_r.added;
  assign out_lex_mode   = out_r.lex_mode;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("Skid entry held while the output register is empty.");

  a_added_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_added != 2'd3)
    else $error("More than two counts reported for one item.");

  a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_restart) |=> count_r == 32'($past(hits)))
    else $error("Count after restart does not match the counts of that item.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_restart && count_r < 32'hFFFF_FFF0) |=>
      count_r == $past(count_r) + 32'($past(hits)))
    else $error("Count did not advance by the counts of the item.");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(count_r) && $stable(tl_r))
    else $error("Lexer state changed without an accepted item.");

endmodule
